// File: rtl/stp_pkg.sv
`timescale 1ns / 1ps

package stp_pkg;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;

  // Bases
  localparam logic [4:0] BASE_OCT = 5'd8;
  localparam logic [4:0] BASE_DEC = 5'd10;
  localparam logic [4:0] BASE_HEX = 5'd16;
  localparam logic [4:0] BASE_AUTO = 5'd0;

  // Digit value that no base accepts
  localparam logic [5:0] DIGIT_NONE = 6'd32;

  // Offset width is tied to the stop_offset field
  localparam int OFFSET_WIDTH = 16;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SPACE  = 3'd1,
    PH_SIGNED = 3'd2,
    PH_ZERO   = 3'd3,
    PH_XSEEN  = 3'd4,
    PH_DIGITS = 3'd5,
    PH_DONE   = 3'd6
  } stp_phase_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       first;
  } stp_in_t;

  typedef struct packed {
    logic signed [63:0]        value;
    logic [OFFSET_WIDTH-1:0]   stop_offset;
  } stp_out_t;

  // Parser control state (accumulator travels separately, its width varies)
  typedef struct packed {
    stp_phase_t              phase;
    logic                    minus_seen;
    logic [4:0]              working_base;
    logic [OFFSET_WIDTH-1:0] char_count;
    logic [OFFSET_WIDTH-1:0] prefix_end;
  } stp_ctrl_t;

  // Digit value of a character, DIGIT_NONE if not a hex digit
  function automatic logic [5:0] digit_of(input logic [7:0] c);
    logic [5:0] d;
    d = DIGIT_NONE;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = 6'(c - CH_ZERO);
    end else if (c >= CH_LA && c <= CH_LF_HEX) begin
      d = 6'(c - CH_LA) + 6'd10;
    end else if (c >= CH_UA && c <= CH_UF) begin
      d = 6'(c - CH_UA) + 6'd10;
    end
    return d;
  endfunction

endpackage

// File: rtl/stp_step.sv
`timescale 1ns / 1ps

// Next-state and result logic for one character word
module stp_step
  import stp_pkg::*;
#(
  parameter int VALUE_WIDTH = 64
) (
  input  stp_in_t                word_in,
  input  logic [4:0]             requested_base,
  input  stp_ctrl_t              ctrl_cur,
  input  logic [VALUE_WIDTH-1:0] acc_cur,
  output stp_ctrl_t              ctrl_nxt,
  output logic [VALUE_WIDTH-1:0] acc_nxt,
  output logic                   emit,
  output stp_out_t               result
);

  localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = '1;

  stp_ctrl_t              ctrl_eff;
  logic [VALUE_WIDTH-1:0] acc_eff;
  logic [5:0]             digit;
  logic [4:0]             base_lead;
  logic [VALUE_WIDTH-1:0] prod;
  logic [VALUE_WIDTH-1:0] mag;
  logic [VALUE_WIDTH-1:0] signed_mag;
  logic [OFFSET_WIDTH-1:0] emit_offset;
  logic                   is_ws;
  logic                   is_x;
  logic                   lead_char;
  logic                   zero_lead;
  logic                   lead_ok;
  logic                   digit_ok;

  // A first-flagged word restarts the parse
  always_comb begin
    ctrl_eff = ctrl_cur;
    acc_eff  = acc_cur;
    if (word_in.first) begin
      ctrl_eff.phase        = PH_SPACE;
      ctrl_eff.minus_seen   = 1'b0;
      ctrl_eff.working_base = requested_base;
      ctrl_eff.char_count   = '0;
      ctrl_eff.prefix_end   = '0;
      acc_eff               = '0;
    end
  end

  assign digit = digit_of(word_in.ch);
  assign is_ws = (word_in.ch == CH_SPACE) || (word_in.ch == CH_TAB) ||
                 (word_in.ch == CH_LF);
  assign is_x  = (word_in.ch == CH_LX) || (word_in.ch == CH_UX);

  // First significant character after blanks or sign
  assign lead_char = (ctrl_eff.phase == PH_SIGNED) ||
                     (ctrl_eff.phase == PH_SPACE && !is_ws &&
                      word_in.ch != CH_MINUS && word_in.ch != CH_PLUS);
  // A leading '0' may open a 0x prefix
  assign zero_lead = (word_in.ch == CH_ZERO) &&
                     (ctrl_eff.working_base == BASE_AUTO ||
                      ctrl_eff.working_base == BASE_HEX);
  assign lead_ok   = digit < {1'b0, base_lead};
  assign digit_ok  = digit < {1'b0, ctrl_eff.working_base};

  // Accumulator times a 5-bit base, shift-and-add, wraps to VALUE_WIDTH
  always_comb begin
    prod = '0;
    for (int i = 0; i < 5; i++) begin
      if (ctrl_eff.working_base[i]) begin
        prod = prod + (acc_eff << i);
      end
    end
  end

  // Base used for the first digit after sign or leading zero
  always_comb begin
    base_lead = ctrl_eff.working_base;
    if (ctrl_eff.working_base == BASE_AUTO) begin
      base_lead = (ctrl_eff.phase == PH_ZERO) ? BASE_OCT : BASE_DEC;
    end
  end

  // Result of the current word: stop flag, magnitude and offset
  always_comb begin
    emit        = 1'b0;
    mag         = '0;
    emit_offset = '0;
    unique case (ctrl_eff.phase) inside
      PH_SPACE, PH_SIGNED: begin
        emit = lead_char && !zero_lead && !lead_ok;
      end
      PH_ZERO: begin
        emit        = !is_x && !lead_ok;
        emit_offset = ctrl_eff.char_count;
      end
      PH_XSEEN: begin
        emit        = (digit >= {1'b0, BASE_HEX});
        emit_offset = ctrl_eff.prefix_end;
      end
      PH_DIGITS: begin
        emit        = !digit_ok;
        mag         = acc_eff;
        emit_offset = ctrl_eff.char_count;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Phase transitions
  always_comb begin
    ctrl_nxt = ctrl_eff;
    acc_nxt  = acc_eff;

    unique case (ctrl_eff.phase) inside
      PH_SPACE, PH_SIGNED: begin
        if (lead_char) begin
          if (zero_lead) begin
            acc_nxt        = '0;
            ctrl_nxt.phase = PH_ZERO;
          end else begin
            ctrl_nxt.working_base = base_lead;
            if (lead_ok) begin
              acc_nxt        = VALUE_WIDTH'(digit);
              ctrl_nxt.phase = PH_DIGITS;
            end
          end
        end else if (word_in.ch == CH_MINUS) begin
          ctrl_nxt.minus_seen = 1'b1;
          ctrl_nxt.phase      = PH_SIGNED;
        end else if (word_in.ch == CH_PLUS) begin
          ctrl_nxt.phase = PH_SIGNED;
        end
      end
      PH_ZERO: begin
        if (is_x) begin
          ctrl_nxt.working_base = BASE_HEX;
          ctrl_nxt.prefix_end   = ctrl_eff.char_count;
          ctrl_nxt.phase        = PH_XSEEN;
        end else begin
          ctrl_nxt.working_base = base_lead;
          if (lead_ok) begin
            acc_nxt        = VALUE_WIDTH'(digit);
            ctrl_nxt.phase = PH_DIGITS;
          end
        end
      end
      PH_XSEEN: begin
        if (digit < {1'b0, BASE_HEX}) begin
          acc_nxt        = VALUE_WIDTH'(digit);
          ctrl_nxt.phase = PH_DIGITS;
        end
      end
      PH_DIGITS: begin
        if (digit_ok) begin
          acc_nxt = prod + VALUE_WIDTH'(digit);
        end
      end
      default: begin
        ctrl_nxt.phase = ctrl_eff.phase;
      end
    endcase

    if (emit) begin
      ctrl_nxt.phase = PH_DONE;
    end

    // Position counter advances on every parsed word, saturating
    if (ctrl_eff.phase != PH_IDLE && ctrl_eff.phase != PH_DONE &&
        ctrl_eff.char_count != OFFSET_MAX) begin
      ctrl_nxt.char_count = ctrl_eff.char_count + 1'b1;
    end
  end

  // Signed result, sign-extended to the port width
  assign signed_mag         = ctrl_eff.minus_seen ? (~mag + 1'b1) : mag;
  assign result.value       = 64'($signed(signed_mag));
  assign result.stop_offset = emit_offset;

endmodule

// File: rtl/string_to_integer_parser.sv
`timescale 1ns / 1ps

// String-to-integer parser with automatic base detection.
// Input channel: one character word per handshake (in_data.ch, in_data.first),
// accepted when in_valid is high and in_stall is low. in_data.first marks the
// first character of a new string; a NUL or any non-digit ends the number.
// Output channel: one word per string (out_data.value, out_data.stop_offset),
// taken when out_valid is high and out_stall is low.
// Configuration: cfg_we writes cfg_wdata as the base (0 = auto-detect); it is
// sampled when a string starts. Reset value is 10.
// Throughput: one character per cycle while in_stall is low. Each word is
// registered at the input, then parsed in one pass (one accumulator times
// 5-bit base add); out_valid rises once the stopping word has been parsed.
// Stall: a pending result holds in the output register; the input register
// keeps taking words until a word waits behind the stalled result, at which
// point in_stall rises.
// Reset (rst_n low, synchronous) empties both registers, returns the parser
// to idle and the base register to 10.
module string_to_integer_parser
  import stp_pkg::*;
#(
  parameter int VALUE_WIDTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  stp_in_t    in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output stp_out_t   out_data,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata
);

  logic                   in_valid_r, in_valid_nxt;
  stp_in_t                in_word_r;
  logic                   out_valid_r, out_valid_nxt;
  stp_out_t               out_word_r;
  logic [4:0]             base_r;
  stp_ctrl_t              ctrl_r, ctrl_nxt;
  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  logic                   emit;
  stp_out_t               result;
  logic                   advance;
  logic                   in_take;

  // Parse the registered word when the output slot is free
  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  stp_step #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_step (
    .word_in       (in_word_r),
    .requested_base(base_r),
    .ctrl_cur      (ctrl_r),
    .acc_cur       (acc_r),
    .ctrl_nxt      (ctrl_nxt),
    .acc_nxt       (acc_nxt),
    .emit          (emit),
    .result        (result)
  );

  // Valid flags
  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r          <= 1'b0;
      out_valid_r         <= 1'b0;
      base_r              <= BASE_DEC;
      ctrl_r.phase        <= PH_IDLE;
      ctrl_r.minus_seen   <= 1'b0;
      ctrl_r.working_base <= '0;
      ctrl_r.char_count   <= '0;
      ctrl_r.prefix_end   <= '0;
      acc_r               <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        base_r <= cfg_wdata;
      end
      if (advance) begin
        ctrl_r <= ctrl_nxt;
        acc_r  <= acc_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_word_r <= in_data;
    end
    if (advance && emit) begin
      out_word_r <= result;
    end
  end

endmodule
